FILE: sv/conv3x3_image_filter_assert.svh
// ----------------------------------------------------------------------------
// conv3x3 image filter assertion macros
// Shared property forms for the checker of the 3x3 filter.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_IMAGE_FILTER_ASSERT_SVH
`define CONV3X3_IMAGE_FILTER_ASSERT_SVH

// same-cycle implication, off while reset is high
`define C3F_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("c3f check failed");

// next-cycle implication, off while reset is high
`define C3F_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("c3f check failed");

// condition that must hold in the cycle after reset
`define C3F_ASSERT_AFTER_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("c3f check failed after reset");

`endif

FILE: sv/c3f_pkg.sv
// ----------------------------------------------------------------------------
// c3f_pkg
// Types, constants and helpers shared by the 3x3 image filter modules.
// ----------------------------------------------------------------------------
package c3f_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int PIX_W       = 8;
   localparam int COEF_W      = 8;
   localparam int TAPS        = 3;
   localparam int WIN_SIZE    = TAPS * TAPS;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int DIM_W       = 11;
   localparam int POS_W       = 10;
   localparam int CSR_W       = 24;
   localparam int CSR_IDX_W   = 3;
   localparam int OUT_W       = 20;
   localparam int PROD_W      = PIX_W + 1 + COEF_W;
   localparam int ROW_W       = PROD_W + 2;
   localparam int SUM_W       = PROD_W + 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_TOP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MID    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_BOTTOM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd4;

   // reset values
   localparam logic [CSR_W-1:0] KERNEL_TOP_RST    = 24'h050403;
   localparam logic [CSR_W-1:0] KERNEL_MID_RST    = 24'h080706;
   localparam logic [CSR_W-1:0] KERNEL_BOTTOM_RST = 24'h0B0A09;
   localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST   = 11'd6;
   localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST  = 11'd6;

   localparam logic [DIM_W-1:0] DIM_MIN    = 11'd3;
   localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

   // first row / column whose window lies fully inside the frame
   localparam int FIRST_INNER = TAPS - 1;

   localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'((2 ** (OUT_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_W'(2 ** (OUT_W - 1));

   typedef struct packed {
      logic [WIN_SIZE-1:0][PIX_W-1:0] pix;
      logic [POS_W-1:0]               centre_row;
      logic [POS_W-1:0]               centre_col;
      logic                           last;
   } c3f_entry_type;

   // one coefficient of a kernel row, left column in the low byte
   function automatic logic [COEF_W-1:0] coef(input logic [CSR_W-1:0] row_reg,
                                              input int idx);
      return row_reg[idx*COEF_W +: COEF_W];
   endfunction

   // unsigned pixel times signed coefficient
   function automatic logic signed [PROD_W-1:0] mul(input logic [PIX_W-1:0] p,
                                                    input logic [COEF_W-1:0] c);
      logic signed [PROD_W-1:0] a;
      logic signed [PROD_W-1:0] b;
      a = $signed({{(PROD_W - PIX_W){1'b0}}, p});
      b = $signed({{(PROD_W - COEF_W){c[COEF_W-1]}}, c});
      return a * b;
   endfunction

endpackage

FILE: sv/conv3x3_image_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// 3x3 correlation over a raster pixel stream with one line store holding two rows.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_pixel, req_frame_start
//   rsp      out        rsp_valid/rsp_ready   rsp_filtered_value, rsp_centre_row,
//                                             rsp_centre_col, rsp_last_of_frame
//   csr      in         csr_wr_en             csr_index, csr_wdata
//
// One pixel per cycle is accepted while req_ready is high; the line store has one
// read and one write port, and each pixel reads and writes it once.
// A pixel passes the s1 registers, the queue and the b1, b2 and result registers.
// A four-entry queue parts the front from the multiply pipeline; req_ready
// drops only when the queue and the pixel in flight fill it.
// Synchronous reset clears counters and pipeline valids; the line store is not
// cleared and needs no setup pass.
// ----------------------------------------------------------------------------
module conv3x3_image_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [c3f_pkg::PIX_W-1:0]         req_pixel,
   input  logic                              req_frame_start,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [c3f_pkg::OUT_W-1:0]  rsp_filtered_value,
   output logic [c3f_pkg::POS_W-1:0]         rsp_centre_row,
   output logic [c3f_pkg::POS_W-1:0]         rsp_centre_col,
   output logic                              rsp_last_of_frame,
   input  logic                              csr_wr_en,
   input  logic [c3f_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [c3f_pkg::CSR_W-1:0]         csr_wdata
);

   logic [c3f_pkg::TAPS-1:0][c3f_pkg::CSR_W-1:0]  kernel_ff;
   logic [c3f_pkg::DIM_W-1:0]                     width_ff, height_ff;
   logic                                          push_valid, pop_valid, pop_ready;
   c3f_pkg::c3f_entry_type                        push_data, pop_data;
   logic [c3f_pkg::QCNT_W-1:0]                    queue_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff[0] <= c3f_pkg::KERNEL_TOP_RST;
         kernel_ff[1] <= c3f_pkg::KERNEL_MID_RST;
         kernel_ff[2] <= c3f_pkg::KERNEL_BOTTOM_RST;
         width_ff     <= c3f_pkg::IMAGE_WIDTH_RST;
         height_ff    <= c3f_pkg::IMAGE_HEIGHT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            c3f_pkg::CSR_KERNEL_TOP:    kernel_ff[0] <= csr_wdata;
            c3f_pkg::CSR_KERNEL_MID:    kernel_ff[1] <= csr_wdata;
            c3f_pkg::CSR_KERNEL_BOTTOM: kernel_ff[2] <= csr_wdata;
            c3f_pkg::CSR_IMAGE_WIDTH:   width_ff     <= csr_wdata[c3f_pkg::DIM_W-1:0];
            c3f_pkg::CSR_IMAGE_HEIGHT:  height_ff    <= csr_wdata[c3f_pkg::DIM_W-1:0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   c3f_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .image_width     (width_ff),
      .image_height    (height_ff),
      .queue_count     (queue_count),
      .push_valid      (push_valid),
      .push_data       (push_data)
   );

   c3f_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .count      (queue_count)
   );

   c3f_back u_back (
      .clock              (clock),
      .reset              (reset),
      .kernel             (kernel_ff),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_data           (pop_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_centre_row     (rsp_centre_row),
      .rsp_centre_col     (rsp_centre_col),
      .rsp_last_of_frame  (rsp_last_of_frame)
   );

endmodule

FILE: sv/c3f_front.sv
// ----------------------------------------------------------------------------
// c3f_front
// Position counters, line store and 3x3 window; pushes interior windows.
// ----------------------------------------------------------------------------
module c3f_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [c3f_pkg::PIX_W-1:0]     req_pixel,
   input  logic                          req_frame_start,
   input  logic [c3f_pkg::DIM_W-1:0]     image_width,
   input  logic [c3f_pkg::DIM_W-1:0]     image_height,
   input  logic [c3f_pkg::QCNT_W-1:0]    queue_count,
   output logic                          push_valid,
   output c3f_pkg::c3f_entry_type        push_data
);

   localparam int LW = 2 * c3f_pkg::PIX_W;

   logic                         accept;
   logic [c3f_pkg::DIM_W-1:0]    w_lim, h_lim;
   logic [c3f_pkg::DIM_W-1:0]    col_start, row_start, col_wrap, row_step, row_wrap;
   logic [c3f_pkg::DIM_W-1:0]    col_next, row_next;
   logic [c3f_pkg::ADDR_W-1:0]   col_ff, col_in, cur_col;
   logic [c3f_pkg::POS_W-1:0]    row_ff, row_in, cur_row;
   logic                         is_inner, is_last;

   logic                         s1_vld_ff;
   logic [c3f_pkg::PIX_W-1:0]    s1_pix_ff;
   logic [c3f_pkg::ADDR_W-1:0]   s1_col_ff;
   logic [c3f_pkg::POS_W-1:0]    s1_crow_ff, s1_ccol_ff;
   logic                         s1_inner_ff, s1_last_ff;

   logic [LW-1:0]                line_mem [c3f_pkg::MAX_WIDTH];
   logic [LW-1:0]                rd_data_ff;
   logic                         wr_vld_ff;
   logic [c3f_pkg::ADDR_W-1:0]   wr_addr_ff;
   logic [LW-1:0]                wr_data_ff, wr_data_in, line_fwd;
   logic [c3f_pkg::PIX_W-1:0]    up_pix, lo_pix;

   logic [c3f_pkg::PIX_W-1:0]    win_ff [c3f_pkg::WIN_SIZE];
   logic [c3f_pkg::PIX_W-1:0]    win_in [c3f_pkg::WIN_SIZE];

   // credit: one transaction may still be in flight toward the queue
   assign req_ready = ((c3f_pkg::QCNT_W + 1)'(queue_count) +
                       (c3f_pkg::QCNT_W + 1)'(s1_vld_ff)) <
                      (c3f_pkg::QCNT_W + 1)'(c3f_pkg::QUEUE_DEPTH);
   assign accept = req_valid && req_ready;

   always_comb begin
      w_lim = image_width;
      if (image_width < c3f_pkg::DIM_MIN) begin
         w_lim = c3f_pkg::DIM_MIN;
      end else if (image_width > c3f_pkg::WIDTH_MAX) begin
         w_lim = c3f_pkg::WIDTH_MAX;
      end
      h_lim = image_height;
      if (image_height < c3f_pkg::DIM_MIN) begin
         h_lim = c3f_pkg::DIM_MIN;
      end else if (image_height > c3f_pkg::HEIGHT_MAX) begin
         h_lim = c3f_pkg::HEIGHT_MAX;
      end

      col_start = req_frame_start ? '0 : c3f_pkg::DIM_W'(col_ff);
      row_start = req_frame_start ? '0 : c3f_pkg::DIM_W'(row_ff);
      // fold counters that the geometry no longer covers
      if (col_start >= w_lim) begin
         col_wrap = '0;
         row_step = row_start + c3f_pkg::DIM_W'(1);
      end else begin
         col_wrap = col_start;
         row_step = row_start;
      end
      row_wrap = (row_step >= h_lim) ? '0 : row_step;
      cur_col  = col_wrap[c3f_pkg::ADDR_W-1:0];
      cur_row  = row_wrap[c3f_pkg::POS_W-1:0];

      col_next = c3f_pkg::DIM_W'(cur_col) + c3f_pkg::DIM_W'(1);
      row_next = c3f_pkg::DIM_W'(cur_row) + c3f_pkg::DIM_W'(1);
      if (col_next >= w_lim) begin
         col_in = '0;
         row_in = (row_next >= h_lim) ? '0 : row_next[c3f_pkg::POS_W-1:0];
      end else begin
         col_in = col_next[c3f_pkg::ADDR_W-1:0];
         row_in = cur_row;
      end

      is_inner = (cur_row >= c3f_pkg::POS_W'(c3f_pkg::FIRST_INNER)) &&
                 (cur_col >= c3f_pkg::ADDR_W'(c3f_pkg::FIRST_INNER));
      is_last  = (c3f_pkg::DIM_W'(cur_row) == h_lim - c3f_pkg::DIM_W'(1)) &&
                 (c3f_pkg::DIM_W'(cur_col) == w_lim - c3f_pkg::DIM_W'(1));
   end

   // take the write landing on the same edge as this read
   assign line_fwd   = (wr_vld_ff && (wr_addr_ff == s1_col_ff)) ? wr_data_ff : rd_data_ff;
   assign up_pix     = line_fwd[LW-1:c3f_pkg::PIX_W];
   assign lo_pix     = line_fwd[c3f_pkg::PIX_W-1:0];
   assign wr_data_in = {lo_pix, s1_pix_ff};

   always_comb begin
      for (int r = 0; r < c3f_pkg::TAPS; r++) begin
         for (int c = 0; c < c3f_pkg::TAPS - 1; c++) begin
            win_in[r*c3f_pkg::TAPS + c] = win_ff[r*c3f_pkg::TAPS + c + 1];
         end
      end
      win_in[c3f_pkg::TAPS - 1]       = up_pix;
      win_in[2*c3f_pkg::TAPS - 1]     = lo_pix;
      win_in[c3f_pkg::WIN_SIZE - 1]   = s1_pix_ff;
   end

   always_comb begin
      for (int i = 0; i < c3f_pkg::WIN_SIZE; i++) begin
         push_data.pix[i] = win_in[i];
      end
      push_data.centre_row = s1_crow_ff;
      push_data.centre_col = s1_ccol_ff;
      push_data.last       = s1_last_ff;
   end
   assign push_valid = s1_vld_ff && s1_inner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         s1_vld_ff <= 1'b0;
         wr_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         s1_vld_ff <= accept;
         wr_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff  <= line_mem[cur_col];
         s1_pix_ff   <= req_pixel;
         s1_col_ff   <= cur_col;
         s1_crow_ff  <= cur_row - c3f_pkg::POS_W'(1);
         s1_ccol_ff  <= c3f_pkg::POS_W'(cur_col) - c3f_pkg::POS_W'(1);
         s1_inner_ff <= is_inner;
         s1_last_ff  <= is_last;
      end
      if (s1_vld_ff) begin
         line_mem[s1_col_ff] <= wr_data_in;
         win_ff              <= win_in;
      end
      wr_addr_ff <= s1_col_ff;
      wr_data_ff <= wr_data_in;
   end

endmodule

FILE: sv/c3f_queue.sv
// ----------------------------------------------------------------------------
// c3f_queue
// Short queue of window transactions between front and back.
// ----------------------------------------------------------------------------
module c3f_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  c3f_pkg::c3f_entry_type        push_data,
   output logic                          pop_valid,
   input  logic                          pop_ready,
   output c3f_pkg::c3f_entry_type        pop_data,
   output logic [c3f_pkg::QCNT_W-1:0]    count
);

   c3f_pkg::c3f_entry_type            slot_ff [c3f_pkg::QUEUE_DEPTH];
   logic [c3f_pkg::QPTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [c3f_pkg::QCNT_W-1:0]        count_ff;
   logic                              do_pop;

   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign do_pop    = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + c3f_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + c3f_pkg::QPTR_W'(1);
         end
         if (push_valid && !do_pop) begin
            count_ff <= count_ff + c3f_pkg::QCNT_W'(1);
         end else if (!push_valid && do_pop) begin
            count_ff <= count_ff - c3f_pkg::QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/c3f_back.sv
// ----------------------------------------------------------------------------
// c3f_back
// Nine products, row sums, total with saturation, held in the result register.
// ----------------------------------------------------------------------------
module c3f_back (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic [c3f_pkg::TAPS-1:0][c3f_pkg::CSR_W-1:0]   kernel,
   input  logic                                           pop_valid,
   output logic                                           pop_ready,
   input  c3f_pkg::c3f_entry_type                         pop_data,
   output logic                                           rsp_valid,
   input  logic                                           rsp_ready,
   output logic signed [c3f_pkg::OUT_W-1:0]               rsp_filtered_value,
   output logic [c3f_pkg::POS_W-1:0]                      rsp_centre_row,
   output logic [c3f_pkg::POS_W-1:0]                      rsp_centre_col,
   output logic                                           rsp_last_of_frame
);

   logic                               en1, en2, en3;
   logic                               b1_vld_ff, b2_vld_ff, rsp_vld_ff;
   logic signed [c3f_pkg::PROD_W-1:0]  prod_ff [c3f_pkg::WIN_SIZE];
   logic signed [c3f_pkg::PROD_W-1:0]  prod_in [c3f_pkg::WIN_SIZE];
   logic signed [c3f_pkg::ROW_W-1:0]   rsum_ff [c3f_pkg::TAPS];
   logic signed [c3f_pkg::ROW_W-1:0]   rsum_in [c3f_pkg::TAPS];
   logic signed [c3f_pkg::SUM_W-1:0]   total;
   logic signed [c3f_pkg::SUM_W-1:0]   sat;
   logic [c3f_pkg::POS_W-1:0]          b1_row_ff, b1_col_ff, b2_row_ff, b2_col_ff;
   logic                               b1_last_ff, b2_last_ff;

   // advance a stage when the one after it is empty or moving
   assign en3       = !rsp_vld_ff || rsp_ready;
   assign en2       = !b2_vld_ff || en3;
   assign en1       = !b1_vld_ff || en2;
   assign pop_ready = en1;
   assign rsp_valid = rsp_vld_ff;

   always_comb begin
      for (int r = 0; r < c3f_pkg::TAPS; r++) begin
         for (int c = 0; c < c3f_pkg::TAPS; c++) begin
            prod_in[r*c3f_pkg::TAPS + c] =
               c3f_pkg::mul(pop_data.pix[r*c3f_pkg::TAPS + c],
                            c3f_pkg::coef(kernel[r], c));
         end
      end
      for (int r = 0; r < c3f_pkg::TAPS; r++) begin
         rsum_in[r] = c3f_pkg::ROW_W'(prod_ff[r*c3f_pkg::TAPS]) +
                      c3f_pkg::ROW_W'(prod_ff[r*c3f_pkg::TAPS + 1]) +
                      c3f_pkg::ROW_W'(prod_ff[r*c3f_pkg::TAPS + 2]);
      end
      total = c3f_pkg::SUM_W'(rsum_ff[0]) + c3f_pkg::SUM_W'(rsum_ff[1]) +
              c3f_pkg::SUM_W'(rsum_ff[2]);
      if (total > c3f_pkg::SUM_HI) begin
         sat = c3f_pkg::SUM_HI;
      end else if (total < c3f_pkg::SUM_LO) begin
         sat = c3f_pkg::SUM_LO;
      end else begin
         sat = total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff  <= 1'b0;
         b2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (en1) begin
            b1_vld_ff <= pop_valid;
         end
         if (en2) begin
            b2_vld_ff <= b1_vld_ff;
         end
         if (en3) begin
            rsp_vld_ff <= b2_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && pop_valid) begin
         prod_ff    <= prod_in;
         b1_row_ff  <= pop_data.centre_row;
         b1_col_ff  <= pop_data.centre_col;
         b1_last_ff <= pop_data.last;
      end
      if (en2 && b1_vld_ff) begin
         rsum_ff    <= rsum_in;
         b2_row_ff  <= b1_row_ff;
         b2_col_ff  <= b1_col_ff;
         b2_last_ff <= b1_last_ff;
      end
      if (en3 && b2_vld_ff) begin
         rsp_filtered_value <= sat[c3f_pkg::OUT_W-1:0];
         rsp_centre_row     <= b2_row_ff;
         rsp_centre_col     <= b2_col_ff;
         rsp_last_of_frame  <= b2_last_ff;
      end
   end

endmodule

FILE: sv/c3f_checker.sv
// ----------------------------------------------------------------------------
// c3f_checker
// Port-level checks on the 3x3 filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "conv3x3_image_filter_assert.svh"

module c3f_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [c3f_pkg::OUT_W-1:0]  rsp_filtered_value,
   input logic [c3f_pkg::POS_W-1:0]         rsp_centre_row,
   input logic [c3f_pkg::POS_W-1:0]         rsp_centre_col,
   input logic                              rsp_last_of_frame
);

   // hold a stalled result transaction
   `C3F_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `C3F_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_filtered_value) && $stable(rsp_centre_row) && $stable(rsp_centre_col) && $stable(rsp_last_of_frame))
   // border centres never come out
   `C3F_ASSERT_SAME(a_rsp_inner, rsp_valid, (rsp_centre_row != '0) && (rsp_centre_col != '0))
   `C3F_ASSERT_AFTER_RESET(a_rsp_reset, !rsp_valid)

endmodule

bind conv3x3_image_filter c3f_checker u_checker (.*);

FILE: tb/sv/conv3x3_image_filter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv3x3_image_filter_test
// Streams raster frames through the 3x3 filter and checks every result.
// A shadow of the line stores, window, counters and kernel predicts each
// interior sum with its centre position and end-of-frame flag. Frames cover
// reset settings, clamped and extreme geometries, saturated kernels, restarts
// and width/height changes in mid frame, with random stalls on both sides.
// ----------------------------------------------------------------------------
module conv3x3_image_filter_test;
   import c3f_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS  = 900;
   localparam int TALL_ROWS     = 200;
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLD     = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = CSR_IMAGE_HEIGHT + 1'b1;

   typedef enum {PIX_RANDOM, PIX_EXTREME, PIX_NEAR_EDGE} pixel_mode_type;

   typedef struct {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } pixel_item_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] value;
      logic [POS_W-1:0]        row;
      logic [POS_W-1:0]        col;
      logic                    last;
   } filter_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [PIX_W-1:0]        req_pixel = '0;
   logic                    req_frame_start = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_filtered_value;
   logic [POS_W-1:0]        rsp_centre_row;
   logic [POS_W-1:0]        rsp_centre_col;
   logic                    rsp_last_of_frame;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_W-1:0]        csr_wdata = '0;

   conv3x3_image_filter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel          (req_pixel),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_centre_row     (rsp_centre_row),
      .rsp_centre_col     (rsp_centre_col),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   pixel_item_type    pending_pixels[$];
   filter_result_type expected_results[$];
   pixel_item_type    next_item;
   filter_result_type want;

   int   items_queued  = 0;
   int   fail_count    = 0;
   int   cycle_count   = 0;
   int   send_idle_pct = 20;
   int   recv_idle_pct = 20;
   int   send_gap      = 0;
   int   ready_gap     = 0;
   int   holds_asked   = 0;
   int   holds_served  = 0;
   logic req_taken     = 1'b0;

   // shadow of the filter state
   logic [CSR_W-1:0] kernel_rows [3] = '{KERNEL_TOP_RST, KERNEL_MID_RST, KERNEL_BOTTOM_RST};
   logic [DIM_W-1:0] cfg_width  = IMAGE_WIDTH_RST;
   logic [DIM_W-1:0] cfg_height = IMAGE_HEIGHT_RST;
   logic [PIX_W-1:0] line_upper [MAX_WIDTH];
   logic [PIX_W-1:0] line_lower [MAX_WIDTH];
   logic [PIX_W-1:0] win [3][3] = '{default: '0};
   int               col_pos = 0;
   int               row_pos = 0;

   function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
      if (v < DIM_MIN) return DIM_MIN;
      if (v > hi) return hi;
      return v;
   endfunction

   // advance the shadow by one pixel and queue the window sum it yields
   task automatic convolve_pixel(input logic [PIX_W-1:0] pix, input logic fs);
      int                w, h, col, row, acc, r, c;
      logic [PIX_W-1:0]  up, lo;
      filter_result_type res;
      w = clamp_dim(cfg_width, MAX_WIDTH);
      h = clamp_dim(cfg_height, MAX_HEIGHT);
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      col = col_pos;
      row = row_pos;
      up = line_upper[col];
      lo = line_lower[col];
      line_upper[col] = lo;
      line_lower[col] = pix;
      for (r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = up;
      win[1][2] = lo;
      win[2][2] = pix;
      if (row >= FIRST_INNER && col >= FIRST_INNER) begin
         acc = 0;
         for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
               acc += int'(win[r][c]) * int'($signed(kernel_rows[r][c*COEF_W +: COEF_W]));
         res.value = acc[OUT_W-1:0];
         res.row   = POS_W'(row - 1);
         res.col   = POS_W'(col - 1);
         res.last  = (row == h - 1) && (col == w - 1);
         expected_results.push_back(res);
      end
      col_pos = col + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = row + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   // sender: change at the falling edge, hold until the transaction is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold
      end else if (send_gap > 0) begin
         send_gap = send_gap - 1;
         req_valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
         next_item = pending_pixels.pop_front();
         req_valid <= 1'b1;
         req_pixel <= next_item.pixel;
         req_frame_start <= next_item.frame_start;
         if ($urandom_range(0, 99) < send_idle_pct) send_gap = $urandom_range(1, 7);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: random stalls, plus a long hold on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served = holds_served + 1;
         ready_gap = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (ready_gap > 0) begin
         ready_gap = ready_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < recv_idle_pct) ready_gap = $urandom_range(1, 7);
      end
   end

   // monitor: track register writes, predict accepted pixels, check results
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && csr_wr_en) begin
         case (csr_index)
            CSR_KERNEL_TOP:    kernel_rows[0] = csr_wdata;
            CSR_KERNEL_MID:    kernel_rows[1] = csr_wdata;
            CSR_KERNEL_BOTTOM: kernel_rows[2] = csr_wdata;
            CSR_IMAGE_WIDTH:   cfg_width = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:  cfg_height = csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
      if (!reset && req_valid && req_ready) convolve_pixel(req_pixel, req_frame_start);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected transaction: filtered_value %0d row %0d col %0d",
                   rsp_filtered_value, rsp_centre_row, rsp_centre_col);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_filtered_value !== want.value) begin
               $error("filtered_value mismatch: expected %0d, got %0d",
                      want.value, rsp_filtered_value);
               fail_count++;
            end
            if (rsp_centre_row !== want.row) begin
               $error("centre_row mismatch: expected %0d, got %0d", want.row, rsp_centre_row);
               fail_count++;
            end
            if (rsp_centre_col !== want.col) begin
               $error("centre_col mismatch: expected %0d, got %0d", want.col, rsp_centre_col);
               fail_count++;
            end
            if (rsp_last_of_frame !== want.last) begin
               $error("last_of_frame mismatch: expected %0b, got %0b",
                      want.last, rsp_last_of_frame);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("conv3x3_image_filter verification failed");
         $finish;
      end
   end

   task push_pixel(input logic [PIX_W-1:0] p, input logic fs);
      pixel_item_type item;
      item.pixel = p;
      item.frame_start = fs;
      pending_pixels.push_back(item);
      items_queued++;
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel(input pixel_mode_type mode);
      case (mode)
         PIX_EXTREME:
            return $urandom_range(0, 1) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
         PIX_NEAR_EDGE:
            return $urandom_range(0, 1) ? PIX_W'(255 - $urandom_range(0, 3))
                                        : PIX_W'($urandom_range(0, 3));
         default:
            return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] pick_kernel_row();
      logic [CSR_W-1:0] v;
      int               k;
      v = CSR_W'($urandom());
      if ($urandom_range(0, 3) == 0) begin
         for (k = 0; k < TAPS; k++) begin
            case ($urandom_range(0, 3))
               0: v[k*COEF_W +: COEF_W] = 8'h80;
               1: v[k*COEF_W +: COEF_W] = 8'h7F;
               2: v[k*COEF_W +: COEF_W] = 8'h00;
               default: ;
            endcase
         end
      end
      return v;
   endfunction

   // mostly small in-range sizes, now and then a value below the floor
   function automatic int pick_dim(input int hi);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 2);
         1: return DIM_MIN;
         default: return $urandom_range(DIM_MIN, hi);
      endcase
   endfunction

   task write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // size registers take random junk above their width
   task write_dim(input logic [CSR_IDX_W-1:0] idx, input int val);
      logic [CSR_W-1:0] data;
      data = CSR_W'($urandom());
      data[DIM_W-1:0] = DIM_W'(val);
      write_reg(idx, data);
   endtask

   task write_kernel_random();
      write_reg(CSR_KERNEL_TOP, pick_kernel_row());
      write_reg(CSR_KERNEL_MID, pick_kernel_row());
      write_reg(CSR_KERNEL_BOTTOM, pick_kernel_row());
   endtask

   task wait_idle();
      while (pending_pixels.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task queue_frame(input int w, input int h, input pixel_mode_type mode,
                    input bit broken, input bit with_start);
      int total, cut, k;
      logic fs;
      total = w * h;
      cut = broken ? $urandom_range(1, total - 1) : total;
      for (k = 0; k < cut; k++) begin
         fs = with_start && (k == 0);
         if (broken && k > 0 && $urandom_range(0, 19) == 0) fs = 1'b1;
         push_pixel(pick_pixel(mode), fs);
      end
   endtask

   initial begin : stimulus
      int          phase, w_val, h_val, w, h, w2, h2, nframes, f, k, random_base;
      bit          pressure;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset kernel and geometry: three rows of the default frame
      for (k = 0; k < 18; k++) push_pixel(pick_pixel(PIX_EXTREME), k == 0);
      wait_idle();

      // most negative sum, with a frame restart after four pixels
      write_reg(CSR_KERNEL_TOP, 24'h808080);
      write_reg(CSR_KERNEL_MID, 24'h808080);
      write_reg(CSR_KERNEL_BOTTOM, 24'h808080);
      write_dim(CSR_IMAGE_WIDTH, DIM_MIN);
      write_dim(CSR_IMAGE_HEIGHT, DIM_MIN);
      for (k = 0; k < 4; k++) push_pixel(pick_pixel(PIX_RANDOM), k == 0);
      for (k = 0; k < 9; k++) push_pixel({PIX_W{1'b1}}, k == 0);
      wait_idle();

      // most positive sum; writes to unmapped indexes must be dropped
      write_reg(CSR_KERNEL_TOP, 24'h7F7F7F);
      write_reg(CSR_KERNEL_MID, 24'h7F7F7F);
      write_reg(CSR_KERNEL_BOTTOM, 24'h7F7F7F);
      for (k = CSR_UNUSED_LO; k < 2 ** CSR_IDX_W; k++)
         write_reg(CSR_IDX_W'(k), {CSR_W{1'b1}});
      for (k = 0; k < 9; k++) push_pixel({PIX_W{1'b1}}, k == 0);
      wait_idle();

      // tall frame cut short: oversize height and too small width clamp
      write_kernel_random();
      write_dim(CSR_IMAGE_WIDTH, 1);
      write_dim(CSR_IMAGE_HEIGHT, 2 ** DIM_W - 1);
      for (k = 0; k < TAPS * TALL_ROWS; k++) push_pixel(pick_pixel(PIX_RANDOM), k == 0);
      wait_idle();

      random_base = items_queued;
      phase = 0;
      while (items_queued - random_base < RANDOM_ITEMS) begin
         phase++;
         pressure = (phase == 2) || (phase == 17);
         wait_idle();
         if (items_queued - random_base > RANDOM_ITEMS * 4 / 5) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if ($urandom_range(0, 4) == 0) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = $urandom_range(5, 40);
            recv_idle_pct = $urandom_range(5, 40);
         end
         write_kernel_random();
         if (!pressure && $urandom_range(0, 7) == 0) begin
            // stop mid frame after at least three full rows, then narrow the width and pick a new height
            w = $urandom_range(4, 12);
            h = $urandom_range(4, 8);
            write_dim(CSR_IMAGE_WIDTH, w);
            write_dim(CSR_IMAGE_HEIGHT, h);
            k = $urandom_range(3 * w, w * h - 1);
            for (f = 0; f < k; f++) push_pixel(pick_pixel(PIX_RANDOM), f == 0);
            wait_idle();
            w2 = $urandom_range(DIM_MIN, w - 1);
            h2 = $urandom_range(DIM_MIN, 8);
            write_dim(CSR_IMAGE_WIDTH, w2);
            write_dim(CSR_IMAGE_HEIGHT, h2);
            for (f = 0; f < 2 * w2 * h2; f++) push_pixel(pick_pixel(PIX_RANDOM), 1'b0);
         end else begin
            w_val = pressure ? 8 : pick_dim(12);
            h_val = pressure ? 6 : pick_dim(8);
            write_dim(CSR_IMAGE_WIDTH, w_val);
            write_dim(CSR_IMAGE_HEIGHT, h_val);
            if ($urandom_range(0, 4) == 0)
               write_reg(CSR_IDX_W'($urandom_range(CSR_UNUSED_LO, 2 ** CSR_IDX_W - 1)),
                         CSR_W'($urandom()));
            w = clamp_dim(DIM_W'(w_val), MAX_WIDTH);
            h = clamp_dim(DIM_W'(h_val), MAX_HEIGHT);
            nframes = pressure ? 3 : $urandom_range(1, 3);
            // stall the result side while frames keep coming
            if (pressure) holds_asked++;
            for (f = 0; f < nframes; f++)
               queue_frame(w, h, pixel_mode_type'($urandom_range(0, 2)),
                           !pressure && $urandom_range(0, 5) == 0,
                           f == 0 || $urandom_range(0, 1) == 1);
         end
      end
      wait_idle();

      if (fail_count == 0) begin
         $display("conv3x3_image_filter verification clean");
      end else begin
         $display("conv3x3_image_filter verification failed");
      end
      $finish;
   end

endmodule
